/* src/best_candidate_blue_noise_sampler_core_assert.svh */
// assertion macros for the best-candidate sampler checks
`ifndef BEST_CANDIDATE_BLUE_NOISE_SAMPLER_CORE_ASSERT_SVH
`define BEST_CANDIDATE_BLUE_NOISE_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define BCBN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, off during reset
`define BCBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, live during reset too
`define BCBN_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* src/bcbn_pkg.sv */
// shared constants, types and helpers of the best-candidate sampler
`default_nettype none
package bcbn_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int COORD_BITS  = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SCORE_W     = 2 * COORD_BITS;
    localparam int INDEX_W     = 10;
    localparam int CC_W        = 7;
    localparam int TGT_W       = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CC_W-1:0]  CC_RESET  = 7'd16;
    localparam logic [TGT_W-1:0] TGT_RESET = 11'd1024;
    localparam logic [COORD_BITS:0] COORD_ONE = {1'b1, {COORD_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAND_COUNT    = 1'b0,
        REG_SAMPLE_TARGET = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic busy;
        logic score_valid;
    } t_dist_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_APPEND
    } t_state;

endpackage
`default_nettype wire

/* src/bcbn_cand_if.sv */
// candidate input channel
`default_nettype none
interface bcbn_cand_if import bcbn_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cand_x;
    logic [COORD_BITS-1:0] cand_y;
    logic                  restart;

    modport source (output valid, cand_x, cand_y, restart, input ready);
    modport sink   (input valid, cand_x, cand_y, restart, output ready);
endinterface
`default_nettype wire

/* src/bcbn_samp_if.sv */
// sample output channel
`default_nettype none
interface bcbn_samp_if import bcbn_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] sample_x;
    logic [COORD_BITS-1:0] sample_y;
    logic [INDEX_W-1:0]    sample_index;
    logic                  last_sample;

    modport source (output valid, sample_x, sample_y, sample_index, last_sample, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_index, last_sample, output ready);
endinterface
`default_nettype wire

/* src/bcbn_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none
module bcbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* src/bcbn_dist.sv */
// pipelined squared toroidal distance unit
`default_nettype none
module bcbn_dist import bcbn_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire t_point       i_cand,
    input  wire t_point       i_point,
    output t_dist_status      o_status,
    output logic [SCORE_W-1:0] o_score
);
    // shorter way around the unit circle
    function automatic logic [COORD_BITS-1:0] wrap_delta(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS-1:0] d;
        logic [COORD_BITS:0]   e;
        d = (a >= b) ? (a - b) : (b - a);
        e = COORD_ONE - {1'b0, d};
        return (e < {1'b0, d}) ? e[COORD_BITS-1:0] : d;
    endfunction

    logic                  r_v1, r_v2, r_v3;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SCORE_W-1:0]    r_sqx, r_sqy, r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= wrap_delta(i_cand.x, i_point.x);
        r_dy  <= wrap_delta(i_cand.y, i_point.y);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_sum <= r_sqx + r_sqy;
    end

    assign o_status.busy        = r_v1 | r_v2 | r_v3;
    assign o_status.score_valid = r_v3;
    assign o_score              = r_sum;
endmodule
`default_nettype wire

/* src/best_candidate_blue_noise_sampler_core.sv */
// top level of the best-candidate blue-noise sampler
//
// candidates arrive on i_cand (valid/ready, cand_x, cand_y, restart); accepted
// samples leave on o_samp (sample_x, sample_y, sample_index, last_sample).
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// the first candidate after reset or restart becomes sample 0 at once; later
// candidates are scored against every stored sample and each group of as many
// candidates as the count register gives yields one sample, the first best score.
// a scored candidate is swept against the store, one entry per cycle through
// the single read port; then the read and the three distance stages drain and
// the group is updated, with an append step when the group closes. the first
// sample goes straight to append; an ignored candidate leaves the sequencer idle.
// i_cand.ready is high only while the sequencer is idle; one item at a time.
// the result sits in an output register, so the next candidate is scored while
// it waits; if the receiver still stalls when another sample is due, the
// sequencer holds in its append step until the register frees.
// reset clears the count, the open group and the output valid and restores the
// candidate count to 16 and the sample target to 1024; the store needs no
// clearing, since only entries below the count are read.
`default_nettype none
module best_candidate_blue_noise_sampler_core import bcbn_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bcbn_cand_if.sink                  i_cand,
    bcbn_samp_if.source                o_samp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    // configuration
    logic [CC_W-1:0]  r_cc;
    logic [TGT_W-1:0] r_tgt;
    logic [CNT_W-1:0] target;

    // sequencer and pattern state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic             r_done;
    logic [CNT_W-1:0] r_rd_cnt;
    logic             r_rd_v;

    // open group
    logic [CC_W-1:0]    r_seen;
    logic               r_best_valid;
    t_point             r_best;
    logic [SCORE_W-1:0] r_best_score;
    logic [SCORE_W-1:0] r_min;
    t_point             r_cand;

    // output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [INDEX_W-1:0]    r_out_idx;
    logic                  r_out_last;

    // decode of an arriving candidate
    logic             in_xfer;
    logic [CNT_W-1:0] acc_count;
    logic             acc_stop;
    logic             acc_first;

    // control strobes
    logic in_ready;
    logic rd_issue;
    logic rd_last;
    logic app_fire;
    logic out_free;

    // score datapath
    t_point             ram_rdata;
    t_dist_status       dist_st;
    logic [SCORE_W-1:0] dist_score;
    logic               better;
    logic [CC_W-1:0]    need;
    logic [CC_W-1:0]    seen_inc;
    logic [CNT_W-1:0]   count_inc;

    // effective target: zero counts as one, saturate at store depth
    always_comb begin
        if (r_tgt == '0) begin
            target = CNT_W'(1);
        end else if (32'(r_tgt) > 32'(MAX_SAMPLES)) begin
            target = CNT_W'(MAX_SAMPLES);
        end else begin
            target = CNT_W'(r_tgt);
        end
    end

    assign in_xfer   = i_cand.valid & in_ready;
    assign acc_count = i_cand.restart ? '0 : r_count;
    assign acc_stop  = (!i_cand.restart && r_done) || (acc_count >= target);
    assign acc_first = (acc_count == '0);

    assign out_free  = !r_out_valid || o_samp.ready;
    assign rd_last   = (CNT_W'(r_rd_cnt + 1'b1) == r_count);
    assign need      = (r_cc == '0) ? CC_W'(1) : r_cc;
    assign seen_inc  = r_seen + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign better    = !r_best_valid || (r_min > r_best_score);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    priority if (acc_stop) begin
                        n_state = ST_IDLE;
                    end else if (acc_first) begin
                        n_state = ST_APPEND;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_v && !dist_st.busy) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = (seen_inc >= need) ? ST_APPEND : ST_IDLE;
            end
            ST_APPEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        app_fire = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCAN:   rd_issue = 1'b1;
            ST_DRAIN:  ;
            ST_DECIDE: ;
            ST_APPEND: app_fire = out_free;
            default:   ;
        endcase
    end

    assign i_cand.ready = in_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cc         <= CC_RESET;
            r_tgt        <= TGT_RESET;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_rd_cnt     <= '0;
            r_rd_v       <= 1'b0;
            r_seen       <= '0;
            r_best_valid <= 1'b0;
            r_best       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= rd_issue;

            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_CAND_COUNT:    r_cc  <= i_cfg_data[CC_W-1:0];
                    REG_SAMPLE_TARGET: r_tgt <= i_cfg_data[TGT_W-1:0];
                    default:           ;
                endcase
            end

            if (in_xfer) begin
                r_rd_cnt <= '0;
                if (i_cand.restart) begin
                    // open group is dropped
                    r_count      <= '0;
                    r_seen       <= '0;
                    r_best_valid <= 1'b0;
                end
                if (acc_stop) begin
                    r_done <= 1'b1;
                end else if (i_cand.restart) begin
                    r_done <= 1'b0;
                end
                if (!acc_stop && acc_first) begin
                    r_best <= '{x: i_cand.cand_x, y: i_cand.cand_y};
                end else if (i_cand.restart) begin
                    r_best <= '0;
                end
            end

            if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end

            if (r_state == ST_DECIDE) begin
                r_seen       <= seen_inc;
                r_best_valid <= 1'b1;
                if (better) begin
                    r_best <= r_cand;
                end
            end

            if (app_fire) begin
                r_count      <= count_inc;
                r_seen       <= '0;
                r_best_valid <= 1'b0;
                r_best       <= '0;
                if (count_inc >= target) begin
                    r_done <= 1'b1;
                end
            end

            // output register: a new sample may load in the same cycle one leaves
            if (app_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_samp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cand <= '{x: i_cand.cand_x, y: i_cand.cand_y};
            r_min  <= '1;
        end else if (dist_st.score_valid && (dist_score < r_min)) begin
            r_min <= dist_score;
        end
        if (r_state == ST_DECIDE && better) begin
            r_best_score <= r_min;
        end
        if (app_fire) begin
            r_out_x    <= r_best.x;
            r_out_y    <= r_best.y;
            r_out_idx  <= INDEX_W'(r_count);
            r_out_last <= (count_inc >= target);
        end
    end

    // point store: written on append, swept on scoring, never both at once
    bcbn_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (app_fire),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_best),
        .i_raddr (r_rd_cnt[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    bcbn_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_v),
        .i_cand   (r_cand),
        .i_point  (ram_rdata),
        .o_status (dist_st),
        .o_score  (dist_score)
    );

    assign o_samp.valid        = r_out_valid;
    assign o_samp.sample_x     = r_out_x;
    assign o_samp.sample_y     = r_out_y;
    assign o_samp.sample_index = r_out_idx;
    assign o_samp.last_sample  = r_out_last;
endmodule
`default_nettype wire

/* src/bcbn_checker.sv */
// port-level checks of the sampler and their bind
`default_nettype none
`include "best_candidate_blue_noise_sampler_core_assert.svh"
module bcbn_checker import bcbn_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [COORD_BITS-1:0] i_out_x,
    input wire logic [COORD_BITS-1:0] i_out_y,
    input wire logic [INDEX_W-1:0]    i_out_idx,
    input wire logic                  i_out_last
);
    // no sample is pending right after reset
    `BCBN_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

    // a stalled sample stays put
    `BCBN_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_x, i_out_y, i_out_idx, i_out_last}))

    // a new sample is only produced while the input side is closed
    `BCBN_ASSERT_NOW(a_rise_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready))
endmodule

bind best_candidate_blue_noise_sampler_core bcbn_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cand.ready),
    .i_out_valid (o_samp.valid),
    .i_out_ready (o_samp.ready),
    .i_out_x     (o_samp.sample_x),
    .i_out_y     (o_samp.sample_y),
    .i_out_idx   (o_samp.sample_index),
    .i_out_last  (o_samp.last_sample)
);
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the best-candidate blue-noise sampler core
`timescale 1ns / 1ps
module testbench import bcbn_pkg::*;;

    localparam int HALF_PERIOD = 6;
    // slowest legal run is well under 10 ms; this leaves ample margin
    localparam int STOP_NS     = 50_000_000;
    localparam int PHASE_ITEMS = 40;
    localparam int RANDOM_ITEMS = 440;
    localparam int LONG_ITEMS  = 80;

    // one expected sample transfer
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [INDEX_W-1:0]    index;
        logic                  is_last;
    } t_sample_exp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bcbn_cand_if cand_ch ();
    bcbn_samp_if samp_ch ();

    best_candidate_blue_noise_sampler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cand     (cand_ch),
        .o_samp     (samp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the sampler state
    t_point            store_pts [MAX_SAMPLES];
    int unsigned       pts_count;
    int unsigned       group_seen;
    t_point            group_best;
    logic [SCORE_W:0]  group_score;
    bit                group_open;     // a best candidate exists in the open group
    bit                pattern_full;
    logic [CC_W-1:0]   cand_count_reg;
    logic [TGT_W-1:0]  target_reg;

    t_sample_exp       expected_samples [$];
    int                mismatch_cnt = 0;
    bit                idle_on = 1'b0;  // random gaps on both channels
    int                rx_stall = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // per-axis distance on the torus: shorter of the direct and wrapped gap
    function automatic logic [COORD_BITS:0] torus_gap(logic [COORD_BITS-1:0] a,
                                                      logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] e;
        d = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
        e = COORD_ONE - d;
        return (e < d) ? e : d;
    endfunction

    // minimum squared distance from a candidate to every stored sample
    function automatic logic [SCORE_W:0] nearest_dist2(t_point c);
        logic [SCORE_W:0] best;
        logic [SCORE_W:0] dx;
        logic [SCORE_W:0] dy;
        logic [SCORE_W:0] s;
        best = '1;
        for (int i = 0; i < pts_count; i++) begin
            dx = torus_gap(c.x, store_pts[i].x);
            dy = torus_gap(c.y, store_pts[i].y);
            s  = dx * dx + dy * dy;
            if (s < best)
                best = s;
        end
        return best;
    endfunction

    // zero means one, anything past the store size saturates
    function automatic int unsigned limit_count();
        int unsigned t;
        t = (target_reg == '0) ? 1 : target_reg;
        if (t > MAX_SAMPLES)
            t = MAX_SAMPLES;
        return t;
    endfunction

    function automatic void reset_group();
        group_seen  = 0;
        group_best  = '0;
        group_score = '0;
        group_open  = 1'b0;
    endfunction

    function automatic bit push_sample(t_point p, output t_sample_exp r);
        r = '0;
        if (pts_count >= MAX_SAMPLES) begin
            pattern_full = 1'b1;
            return 1'b0;
        end
        store_pts[pts_count] = p;
        r.x     = p.x;
        r.y     = p.y;
        r.index = INDEX_W'(pts_count);
        pts_count++;
        r.is_last = (pts_count >= limit_count());
        if (r.is_last)
            pattern_full = 1'b1;
        return 1'b1;
    endfunction

    // advance the mirror by one accepted candidate; 1 when a sample is due
    function automatic bit sampler_step(t_point c, bit restart, output t_sample_exp r);
        int unsigned      need;
        logic [SCORE_W:0] s;
        t_point           chosen;
        r = '0;
        if (restart) begin
            pts_count    = 0;
            pattern_full = 1'b0;
            reset_group();
        end
        // a target lowered below the count also ends the pattern
        if (pts_count >= limit_count())
            pattern_full = 1'b1;
        if (pattern_full)
            return 1'b0;
        // first sample of a pattern goes straight in
        if (pts_count == 0) begin
            reset_group();
            return push_sample(c, r);
        end
        s = nearest_dist2(c);
        // strict compare keeps the earliest of equal scores
        if (!group_open || s > group_score) begin
            group_open  = 1'b1;
            group_score = s;
            group_best  = c;
        end
        group_seen++;
        need = (cand_count_reg == '0) ? 1 : cand_count_reg;
        if (group_seen >= need) begin
            chosen = group_best;
            reset_group();
            return push_sample(chosen, r);
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // sample channel: receiver stalls and checking
    // ------------------------------------------------------------------

    // random receiver stall bursts while idling is on
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            samp_ch.ready <= 1'b0;
            rx_stall      <= rx_stall - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            samp_ch.ready <= 1'b0;
            rx_stall      <= $urandom_range(0, 17);
        end else begin
            samp_ch.ready <= 1'b1;
        end
    end

    // each sample transfer against the oldest expectation
    always @(posedge i_clk) begin : check_samples
        t_sample_exp want;
        if (i_rst_n && samp_ch.valid === 1'b1 && samp_ch.ready === 1'b1) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample transfer: x=%0d y=%0d index=%0d",
                       samp_ch.sample_x, samp_ch.sample_y, samp_ch.sample_index);
                mismatch_cnt++;
            end else begin
                want = expected_samples.pop_front();
                if (samp_ch.sample_x !== want.x) begin
                    $error("sample_x: expected %0d, actual %0d", want.x, samp_ch.sample_x);
                    mismatch_cnt++;
                end
                if (samp_ch.sample_y !== want.y) begin
                    $error("sample_y: expected %0d, actual %0d", want.y, samp_ch.sample_y);
                    mismatch_cnt++;
                end
                if (samp_ch.sample_index !== want.index) begin
                    $error("sample_index: expected %0d, actual %0d",
                           want.index, samp_ch.sample_index);
                    mismatch_cnt++;
                end
                if (samp_ch.last_sample !== want.is_last) begin
                    $error("last_sample: expected %0d, actual %0d",
                           want.is_last, samp_ch.last_sample);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // candidate channel and register port
    // ------------------------------------------------------------------

    // one candidate transfer, optionally preceded by a gap; valid stays up
    task automatic send_candidate(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                  bit restart);
        t_sample_exp r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk) cand_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge i_clk);
        end
        @(negedge i_clk);
        cand_ch.valid   <= 1'b1;
        cand_ch.cand_x  <= x;
        cand_ch.cand_y  <= y;
        cand_ch.restart <= restart;
        do @(posedge i_clk); while (cand_ch.ready !== 1'b1);
        if (sampler_step('{x: x, y: y}, restart, r))
            expected_samples.insert(expected_samples.size(), r);
    endtask

    // drop valid, let all samples out, then cover a full score sweep
    task automatic settle_block();
        @(negedge i_clk) cand_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (pts_count + 16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CAND_COUNT:    cand_count_reg = val[CC_W-1:0];
            REG_SAMPLE_TARGET: target_reg     = val[TGT_W-1:0];
        endcase
    endtask

    task automatic set_mode(logic [CC_W-1:0] cc, logic [TGT_W-1:0] tgt);
        settle_block();
        write_reg(REG_CAND_COUNT, CFG_DATA_W'(cc));
        write_reg(REG_SAMPLE_TARGET, CFG_DATA_W'(tgt));
    endtask

    // random coordinate, biased toward the wrap and the half-way point
    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 4))
            0, 1:    return COORD_BITS'($urandom);
            2:       return COORD_BITS'($urandom_range(0, 255));
            3:       return 16'hFFFF - COORD_BITS'($urandom_range(0, 255));
            default: return 16'h8000 ^ COORD_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one candidate per sample: coordinate extremes, wrap-around, pattern end
    task automatic test_wrap_extremes();
        set_mode(7'd1, 11'd6);
        send_candidate(16'h0000, 16'h0000, 1'b1);
        send_candidate(16'hFFFF, 16'hFFFF, 1'b0);   // one step away across the wrap
        send_candidate(16'h8000, 16'h8000, 1'b0);   // farthest point on the torus
        send_candidate(16'h0001, 16'h7FFF, 1'b0);
        send_candidate(16'hFFFF, 16'h0000, 1'b0);
        send_candidate(16'h8000, 16'h0000, 1'b0);   // completes the pattern
        send_candidate(16'h1234, 16'h5678, 1'b0);   // ignored
        send_candidate(16'hAAAA, 16'h5555, 1'b1);   // restart after the end
    endtask

    // equal scores keep the first candidate, a larger one replaces it
    task automatic test_first_best_kept();
        set_mode(7'd3, 11'd3);
        send_candidate(16'h0000, 16'h0000, 1'b1);
        send_candidate(16'h0100, 16'h0000, 1'b0);
        send_candidate(16'h0000, 16'h0100, 1'b0);
        send_candidate(16'hFF00, 16'h0000, 1'b0);
        send_candidate(16'h0100, 16'h0100, 1'b0);
        send_candidate(16'h8000, 16'h8000, 1'b0);
        send_candidate(16'h4000, 16'h4000, 1'b0);
    endtask

    // restart discards the open group
    task automatic test_restart_open_group();
        set_mode(7'd3, 11'd8);
        send_candidate(16'h4000, 16'h4000, 1'b1);
        send_candidate(16'hC000, 16'hC000, 1'b0);
        send_candidate(16'h2000, 16'hE000, 1'b0);
        send_candidate(16'h1111, 16'h2222, 1'b1);
        send_candidate(16'h9999, 16'h0F0F, 1'b0);
        send_candidate(16'h7777, 16'hF0F0, 1'b0);
        send_candidate(16'h3333, 16'hCCCC, 1'b0);
    endtask

    // zero count acts as one, zero target as one
    task automatic test_zero_settings();
        set_mode(7'd0, 11'd0);
        send_candidate(16'h0005, 16'h0005, 1'b1);
        send_candidate(16'h0007, 16'h0007, 1'b0);   // ignored, pattern of one
        set_mode(7'd0, 11'd3);
        send_candidate(16'h0100, 16'hF000, 1'b1);
        send_candidate(16'h0200, 16'h0300, 1'b0);
    endtask

    // target lowered under the count ends the pattern until restart
    task automatic test_lowered_target();
        set_mode(7'd1, 11'd10);
        send_candidate(16'h0000, 16'h8000, 1'b1);
        for (int i = 0; i < 3; i++)
            send_candidate(pick_coord(), pick_coord(), 1'b0);
        settle_block();
        write_reg(REG_SAMPLE_TARGET, 11'd3);
        send_candidate(16'h1000, 16'h2000, 1'b0);   // ignored
        settle_block();
        write_reg(REG_SAMPLE_TARGET, 11'd10);
        send_candidate(16'h3000, 16'h4000, 1'b0);   // still ignored
        send_candidate(16'h5000, 16'h6000, 1'b1);
    endtask

    // phases of random patterns over a spread of register settings
    task automatic test_random_patterns();
        logic [CC_W-1:0]       cc;
        logic [TGT_W-1:0]      tgt;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int  total;
        int  taken;
        int  phase;
        bit  rs;
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            idle_on = (phase % 3 != 2);
            case (phase % 8)
                0: begin cc = 7'd1;  tgt = TGT_W'($urandom_range(2, 40)); end
                1: begin cc = 7'd2;  tgt = TGT_W'($urandom_range(2, 24)); end
                2: begin cc = CC_W'($urandom_range(3, 8)); tgt = TGT_W'($urandom_range(2, 12)); end
                3: begin cc = 7'd64; tgt = TGT_W'($urandom_range(2, 8)); end
                4: begin cc = 7'd127; tgt = 11'd2; end
                5: begin cc = CC_W'($urandom_range(1, 5)); tgt = 11'd1024; end
                6: begin cc = CC_W'($urandom_range(1, 4)); tgt = 11'd2047; end
                default: begin cc = 7'd16; tgt = TGT_W'($urandom_range(1, 6)); end
            endcase
            set_mode(cc, tgt);
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                // well-formed: restart to open a pattern, rarely mid-group
                if (taken == 0)
                    rs = ($urandom_range(0, 7) != 0);
                else if (pattern_full)
                    rs = ($urandom_range(0, 3) != 0);
                else
                    rs = ($urandom_range(0, 39) == 0);
                x = pick_coord();
                y = pick_coord();
                if (rs || !(pattern_full || pts_count >= limit_count()))
                    taken++;
                send_candidate(x, y, rs);
            end
            total += taken;
            phase++;
        end
    endtask

    // long pattern with no idling; the target saturates at the store size
    task automatic test_long_pattern();
        idle_on = 1'b0;
        set_mode(7'd1, 11'd2047);
        send_candidate(pick_coord(), pick_coord(), 1'b1);
        for (int i = 1; i < LONG_ITEMS; i++)
            send_candidate(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
        send_candidate(16'h2468, 16'h1357, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_CAND_COUNT;
        i_cfg_data      = '0;
        cand_ch.valid   = 1'b0;
        cand_ch.cand_x  = '0;
        cand_ch.cand_y  = '0;
        cand_ch.restart = 1'b0;
        samp_ch.ready   = 1'b1;
        pts_count       = 0;
        pattern_full    = 1'b0;
        reset_group();
        cand_count_reg  = CC_RESET;
        target_reg      = TGT_RESET;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: a sample 0 and one open group under the defaults
        idle_on = 1'b1;
        send_candidate(16'h0000, 16'hFFFF, 1'b0);
        send_candidate(16'hFFFF, 16'h0000, 1'b0);

        test_wrap_extremes();
        test_first_best_kept();
        test_restart_open_group();
        test_zero_settings();
        test_lowered_target();
        test_random_patterns();
        test_long_pattern();

        settle_block();
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #(STOP_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
